/* rtl/fogr_pkg.sv */
// ----------------------------------------------------------------------------
// fogr_pkg
// Shared types and codes of the FIFO-ordered resource grant unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fogr_pkg;

  localparam int FuncBits = 3;
  localparam int IdFieldBits = 16;
  localparam int RankBits = 4;
  localparam int UseBits = 32;

  localparam logic [FuncBits-1:0] FN_JOIN       = 3'd0;
  localparam logic [FuncBits-1:0] FN_RANK       = 3'd1;
  localparam logic [FuncBits-1:0] FN_GRANT      = 3'd2;
  localparam logic [FuncBits-1:0] FN_JOIN_GRANT = 3'd3;
  localparam logic [FuncBits-1:0] FN_RELEASE    = 3'd4;

  typedef struct packed {
    logic [FuncBits-1:0]    func;
    logic [IdFieldBits-1:0] requester_id;
  } in_word_t;

  typedef struct packed {
    logic                granted;
    logic                found;
    logic [RankBits-1:0] rank;
    logic                busy_res;
    logic                queue_full_drop;
    logic [UseBits-1:0]  use_total;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_APPLY
  } state_t;

endpackage

`default_nettype wire

/* rtl/fogr_ram.sv */
// ----------------------------------------------------------------------------
// fogr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fogr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/fifo_ordered_resource_grant_unit.sv */
// ----------------------------------------------------------------------------
// fifo_ordered_resource_grant_unit
// Grants one shared resource to requesters strictly in the order they joined.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive in_word and raise start; the word is taken at an
//   edge where start is high and busy is low. Functions are join, rank query,
//   grant, join-then-grant and release.
//   Result channel: out_valid is high for exactly one cycle with out_word.
//   The receiver cannot stall; every command yields exactly one result word.
//   Config channel: cfg_data bit 0 closes the resource (grants refused).
//   cfg_ready is high while busy is low, so writes land between commands.
// Queue scan:
//   The wait queue is a circular buffer in one RAM. Each command scans the
//   queue from the head, one entry at a time (read, then compare), stopping
//   on a match or at the last entry; an empty queue is not scanned. The
//   command then passes through the apply state. busy drops in the cycle
//   the result is shown, so the next command can be taken at the edge that
//   ends it.
// Reset:
//   rst_n low clears the queue fill, head, holder, use count and the closed
//   flag. Queue RAM contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_ordered_resource_grant_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire fogr_pkg::in_word_t  in_word,
  output logic                     out_valid,
  output fogr_pkg::out_word_t      out_word,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int RB = fogr_pkg::RankBits;

  fogr_pkg::state_t state_r, state_nxt;

  logic [fogr_pkg::FuncBits-1:0] func_r, func_nxt;
  logic [ID_BITS-1:0]            id_r, id_nxt;
  logic [CW-1:0]                 idx_r, idx_nxt;
  logic                          found_r, found_nxt;
  logic [AW-1:0]                 pos_r, pos_nxt;
  logic [AW-1:0]                 head_r, head_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic                          holder_valid_r, holder_valid_nxt;
  logic [ID_BITS-1:0]            holder_id_r, holder_id_nxt;
  logic [fogr_pkg::UseBits-1:0]  use_r, use_nxt;
  logic                          closed_r, closed_nxt;
  logic                          out_valid_r, out_valid_nxt;
  fogr_pkg::out_word_t           out_r, out_nxt;

  logic [ID_BITS+fogr_pkg::IdFieldBits-1:0] id_ext;
  logic [ID_BITS-1:0]                       id_in;
  logic                                     accept;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic [ID_BITS-1:0] ram_rdata;

  logic          is_join, try_grant, joined, dropped, head_is_id, grant_ok, rel_ok;
  logic          found_o;
  logic [CW-1:0] count_j;
  logic [AW-1:0] pos_o;
  logic [AW+RB-1:0] pos_ext;
  logic [SW-1:0] head_inc;

  // Physical address of queue slot i, counted from the head.
  function automatic logic [AW-1:0] slot_addr(input logic [AW-1:0] head,
                                              input logic [CW-1:0] i);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(i);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign id_ext    = {{ID_BITS{1'b0}}, in_word.requester_id};
  assign id_in     = id_ext[ID_BITS-1:0];
  assign busy      = (state_r != fogr_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = !busy;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  fogr_ram #(
    .WIDTH(ID_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(id_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign ram_raddr = slot_addr(head_r, idx_r);
  assign ram_waddr = slot_addr(head_r, count_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fogr_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (count_r == '0) ? fogr_pkg::ST_APPLY : fogr_pkg::ST_READ;
        end
      end
      fogr_pkg::ST_READ: begin
        state_nxt = fogr_pkg::ST_CMP;
      end
      fogr_pkg::ST_CMP: begin
        if (ram_rdata == id_r || idx_r == count_r - CW'(1)) begin
          state_nxt = fogr_pkg::ST_APPLY;
        end else begin
          state_nxt = fogr_pkg::ST_READ;
        end
      end
      fogr_pkg::ST_APPLY: begin
        state_nxt = fogr_pkg::ST_IDLE;
      end
      default: state_nxt = fogr_pkg::ST_IDLE;
    endcase
  end

  // Operation decode for the apply step
  always_comb begin
    is_join    = (func_r == fogr_pkg::FN_JOIN) || (func_r == fogr_pkg::FN_JOIN_GRANT);
    try_grant  = (func_r == fogr_pkg::FN_GRANT) || (func_r == fogr_pkg::FN_JOIN_GRANT);
    joined     = is_join && !found_r && (count_r != CW'(QUEUE_DEPTH));
    dropped    = is_join && !found_r && (count_r == CW'(QUEUE_DEPTH));
    count_j    = joined ? count_r + CW'(1) : count_r;
    head_is_id = (found_r && pos_r == '0) || (joined && count_r == '0);
    grant_ok   = try_grant && !closed_r && !holder_valid_r && head_is_id;
    rel_ok     = (func_r == fogr_pkg::FN_RELEASE) && holder_valid_r && (holder_id_r == id_r);
    // A granted requester leaves the queue; IDs are unique, so it is gone.
    found_o    = !grant_ok && (found_r || joined);
    pos_o      = found_r ? pos_r : count_r[AW-1:0];
    pos_ext    = {{RB{1'b0}}, pos_o};
    head_inc   = SW'(head_r) + SW'(1);
    if (head_inc == SW'(QUEUE_DEPTH)) begin
      head_inc = '0;
    end
  end

  // Datapath and outputs
  always_comb begin
    func_nxt         = func_r;
    id_nxt           = id_r;
    idx_nxt          = idx_r;
    found_nxt        = found_r;
    pos_nxt          = pos_r;
    head_nxt         = head_r;
    count_nxt        = count_r;
    holder_valid_nxt = holder_valid_r;
    holder_id_nxt    = holder_id_r;
    use_nxt          = use_r;
    closed_nxt       = closed_r;
    out_valid_nxt    = 1'b0;
    out_nxt          = out_r;
    ram_we           = 1'b0;

    if (cfg_valid && cfg_ready) begin
      closed_nxt = cfg_data;
    end

    unique case (state_r)
      fogr_pkg::ST_IDLE: begin
        if (accept) begin
          func_nxt  = in_word.func;
          id_nxt    = id_in;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          pos_nxt   = '0;
        end
      end
      fogr_pkg::ST_READ: begin
      end
      fogr_pkg::ST_CMP: begin
        if (ram_rdata == id_r) begin
          found_nxt = 1'b1;
          pos_nxt   = idx_r[AW-1:0];
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      fogr_pkg::ST_APPLY: begin
        ram_we = joined;
        if (grant_ok) begin
          head_nxt         = head_inc[AW-1:0];
          count_nxt        = count_j - CW'(1);
          holder_valid_nxt = 1'b1;
          holder_id_nxt    = id_r;
        end else begin
          count_nxt = count_j;
        end
        if (rel_ok) begin
          holder_valid_nxt = 1'b0;
          holder_id_nxt    = '0;
          use_nxt          = use_r + fogr_pkg::UseBits'(1);
        end
        out_valid_nxt           = 1'b1;
        out_nxt.granted         = grant_ok;
        out_nxt.found           = found_o;
        out_nxt.rank            = found_o ? pos_ext[RB-1:0] : '0;
        out_nxt.busy_res        = holder_valid_nxt;
        out_nxt.queue_full_drop = dropped;
        out_nxt.use_total       = use_nxt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= fogr_pkg::ST_IDLE;
      head_r         <= '0;
      count_r        <= '0;
      holder_valid_r <= 1'b0;
      holder_id_r    <= '0;
      use_r          <= '0;
      closed_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      head_r         <= head_nxt;
      count_r        <= count_nxt;
      holder_valid_r <= holder_valid_nxt;
      holder_id_r    <= holder_id_nxt;
      use_r          <= use_nxt;
      closed_r       <= closed_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    id_r    <= id_nxt;
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    pos_r   <= pos_nxt;
    out_r   <= out_nxt;
  end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives join, rank, grant, join-then-grant, release and undecoded commands
// into the resource grant unit with random sender gaps. A behavioral copy
// of the FIFO wait line predicts the status word for every accepted command.
// Each strobed result is compared field by field with that prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LineDepth = 16;
  localparam int PoolSize  = 20;
  localparam int TailWait  = 40;
  localparam int DueDepth  = 8;

  // function codes the unit does not decode
  localparam logic [fogr_pkg::FuncBits-1:0] FN_SPARE_LO = 3'd5;
  localparam logic [fogr_pkg::FuncBits-1:0] FN_SPARE_HI = 3'd7;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  fogr_pkg::in_word_t  in_word;
  logic                out_valid;
  fogr_pkg::out_word_t out_word;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_data;

  // predicted unit state
  logic [fogr_pkg::IdFieldBits-1:0] wait_line[LineDepth];
  int                               line_fill;
  logic                             owner_valid;
  logic [fogr_pkg::IdFieldBits-1:0] owner_id;
  logic [fogr_pkg::UseBits-1:0]     use_count;
  logic                             closed_now;

  // predicted words, written by the sender and read by the checker
  fogr_pkg::out_word_t              status_due[DueDepth];
  int                               due_wr;
  int                               due_rd;
  logic [fogr_pkg::IdFieldBits-1:0] id_pool[PoolSize];
  int                               send_idle_pct;
  int                               fail_count;

  fifo_ordered_resource_grant_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int line_pos(input logic [fogr_pkg::IdFieldBits-1:0] id);
    for (int i = 0; i < line_fill; i++) begin
      if (wait_line[i] == id) return i;
    end
    return -1;
  endfunction

  // returns 1 when the join is dropped on a full line
  function automatic logic join_line(input logic [fogr_pkg::IdFieldBits-1:0] id);
    if (line_pos(id) >= 0) return 1'b0;
    if (line_fill >= LineDepth) return 1'b1;
    wait_line[line_fill] = id;
    line_fill++;
    return 1'b0;
  endfunction

  function automatic logic try_grant(input logic [fogr_pkg::IdFieldBits-1:0] id);
    if (closed_now || owner_valid || line_fill == 0) return 1'b0;
    if (wait_line[0] != id) return 1'b0;
    // advance the line by one
    for (int i = 1; i < line_fill; i++) wait_line[i - 1] = wait_line[i];
    line_fill--;
    owner_valid = 1'b1;
    owner_id    = id;
    return 1'b1;
  endfunction

  function automatic fogr_pkg::out_word_t predict_status(input fogr_pkg::in_word_t w);
    fogr_pkg::out_word_t r;
    int                  pos;
    r = '0;
    case (w.func)
      fogr_pkg::FN_JOIN: r.queue_full_drop = join_line(w.requester_id);
      fogr_pkg::FN_GRANT: r.granted = try_grant(w.requester_id);
      fogr_pkg::FN_JOIN_GRANT: begin
        r.queue_full_drop = join_line(w.requester_id);
        r.granted         = try_grant(w.requester_id);
      end
      fogr_pkg::FN_RELEASE: begin
        if (owner_valid && owner_id == w.requester_id) begin
          owner_valid = 1'b0;
          owner_id    = '0;
          use_count   = use_count + fogr_pkg::UseBits'(1);
        end
      end
      default: ;
    endcase
    pos         = line_pos(w.requester_id);
    r.found     = (pos >= 0);
    r.rank      = (pos >= 0) ? fogr_pkg::RankBits'(pos) : '0;
    r.busy_res  = owner_valid;
    r.use_total = use_count;
    return r;
  endfunction

  // mostly well-formed traffic over a small ID pool, some noise
  function automatic fogr_pkg::in_word_t pick_cmd();
    fogr_pkg::in_word_t w;
    int                 roll;
    roll           = $urandom_range(99);
    w.requester_id = id_pool[$urandom_range(PoolSize - 1)];
    if (roll < 28) begin
      w.func = fogr_pkg::FN_JOIN;
    end else if (roll < 38) begin
      w.func = fogr_pkg::FN_JOIN_GRANT;
    end else if (roll < 56) begin
      w.func = fogr_pkg::FN_GRANT;
      if (line_fill != 0) w.requester_id = wait_line[0];
    end else if (roll < 60) begin
      w.func = fogr_pkg::FN_GRANT;
    end else if (roll < 75) begin
      w.func = fogr_pkg::FN_RELEASE;
      if (owner_valid) w.requester_id = owner_id;
    end else if (roll < 78) begin
      w.func = fogr_pkg::FN_RELEASE;
    end else if (roll < 90) begin
      w.func = fogr_pkg::FN_RANK;
      if (line_fill != 0)
        w.requester_id = wait_line[$urandom_range(line_fill - 1)];
    end else begin
      w.func         = fogr_pkg::FuncBits'($urandom_range(7));
      w.requester_id = fogr_pkg::IdFieldBits'($urandom);
    end
    return w;
  endfunction

  task automatic send_cmd(input logic [fogr_pkg::FuncBits-1:0] func,
                          input logic [fogr_pkg::IdFieldBits-1:0] id);
    fogr_pkg::in_word_t w;
    w.func         = func;
    w.requester_id = id;
    // idle the sender on a share of the cycles
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    status_due[due_wr % DueDepth] = predict_status(w);
    due_wr++;
  endtask

  // hold commands until every predicted word has been seen
  task automatic drain_results();
    start <= 1'b0;
    while (due_wr != due_rd || busy) @(posedge clk);
  endtask

  task automatic write_closed(input logic closed);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= closed;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    closed_now  = closed;
  endtask

  task automatic check_field(input string name, input logic [fogr_pkg::UseBits-1:0] want,
                             input logic [fogr_pkg::UseBits-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    fogr_pkg::out_word_t want;
    if (rst_n && out_valid) begin
      if (due_wr == due_rd) begin
        $error("result word with nothing outstanding");
        fail_count++;
      end else begin
        want = status_due[due_rd % DueDepth];
        due_rd++;
        check_field("granted", fogr_pkg::UseBits'(want.granted),
                    fogr_pkg::UseBits'(out_word.granted));
        check_field("found", fogr_pkg::UseBits'(want.found),
                    fogr_pkg::UseBits'(out_word.found));
        check_field("rank", fogr_pkg::UseBits'(want.rank),
                    fogr_pkg::UseBits'(out_word.rank));
        check_field("busy_res", fogr_pkg::UseBits'(want.busy_res),
                    fogr_pkg::UseBits'(out_word.busy_res));
        check_field("queue_full_drop", fogr_pkg::UseBits'(want.queue_full_drop),
                    fogr_pkg::UseBits'(out_word.queue_full_drop));
        check_field("use_total", want.use_total, out_word.use_total);
      end
    end
  end

  task automatic test_basic_ops();
    send_cmd(fogr_pkg::FN_RANK, 16'h0000);         // empty line
    send_cmd(fogr_pkg::FN_JOIN, 16'h0000);
    send_cmd(fogr_pkg::FN_JOIN, 16'hFFFF);
    send_cmd(fogr_pkg::FN_JOIN, 16'h0000);         // already queued
    send_cmd(fogr_pkg::FN_GRANT, 16'hFFFF);        // not at head
    send_cmd(fogr_pkg::FN_GRANT, 16'h0000);
    send_cmd(fogr_pkg::FN_GRANT, 16'hFFFF);        // resource held
    send_cmd(fogr_pkg::FN_RELEASE, 16'hFFFF);      // not the holder
    send_cmd(fogr_pkg::FN_RELEASE, 16'h0000);
    send_cmd(FN_SPARE_LO, 16'h5A5A);
    send_cmd(FN_SPARE_HI, 16'hA5A5);
    send_cmd(fogr_pkg::FN_RELEASE, 16'h1234);      // resource free
  endtask

  task automatic test_closed_grant();
    write_closed(1'b1);
    send_cmd(fogr_pkg::FN_GRANT, 16'hFFFF);
    send_cmd(fogr_pkg::FN_JOIN_GRANT, 16'hFFFF);
    write_closed(1'b0);
  endtask

  task automatic test_full_line();
    send_cmd(fogr_pkg::FN_JOIN_GRANT, 16'hFFFF);   // queued at head, granted
    send_cmd(fogr_pkg::FN_GRANT, 16'h2222);        // empty line
    for (int i = 0; i < LineDepth; i++) begin
      send_cmd(fogr_pkg::FN_JOIN, fogr_pkg::IdFieldBits'(16'h0101 * (i + 1)));
    end
    send_cmd(fogr_pkg::FN_JOIN, 16'hBEEF);         // dropped
    send_cmd(fogr_pkg::FN_JOIN_GRANT, 16'hBEEF);   // dropped, grant then fails
    send_cmd(fogr_pkg::FN_RELEASE, 16'hFFFF);
  endtask

  task automatic test_random_mix(input int pct, input logic closed, input int count);
    fogr_pkg::in_word_t w;
    write_closed(closed);
    send_idle_pct = pct;
    for (int i = 0; i < PoolSize; i++) id_pool[i] = fogr_pkg::IdFieldBits'($urandom);
    repeat (count) begin
      w = pick_cmd();
      send_cmd(w.func, w.requester_id);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_word       = '0;
    cfg_valid     = 1'b0;
    cfg_data      = 1'b0;
    line_fill     = 0;
    owner_valid   = 1'b0;
    owner_id      = '0;
    use_count     = '0;
    closed_now    = 1'b0;
    due_wr        = 0;
    due_rd        = 0;
    fail_count    = 0;
    send_idle_pct = 20;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    test_closed_grant();
    test_full_line();
    test_random_mix(20, 1'b1, 305);
    test_random_mix(20, 1'b0, 305);
    test_random_mix(63, 1'b0, 305);
    test_random_mix(63, 1'b1, 305);
    test_random_mix(0, 1'b1, 305);
    test_random_mix(0, 1'b0, 305);

    drain_results();
    repeat (TailWait) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
rtl/fogr_pkg.sv
rtl/fogr_ram.sv
rtl/fifo_ordered_resource_grant_unit.sv
dv/tb_top.sv
